// ===== design/wtso_pkg.sv =====
// ----------------------------------------------------------------------------
// wtso_pkg
// Shared sizes, payload types and status codes of the word table search.
// ----------------------------------------------------------------------------
package wtso_pkg;

   localparam int TableDepth = 8;
   localparam int MaxWordLen = 8;
   localparam int LetterBits = 8;
   localparam int MaxResults = 64;

   localparam int IdxBits = $clog2(TableDepth);
   localparam int PosBits = $clog2(MaxWordLen);
   localparam int LenBits = $clog2(MaxWordLen + 1);
   localparam int CntBits = $clog2(TableDepth + 1);
   localparam int ResBits = $clog2(MaxResults + 1);

   typedef logic [MaxWordLen-1:0][LetterBits-1:0] word_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SUBS   = 2'd1,
      OP_FIRST  = 2'd2,
      OP_SUPERS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_LONG  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] letter;
      logic       word_end;
   } req_type;

   typedef struct packed {
      logic       match_found;
      logic [2:0] table_index;
      logic [2:0] match_position;
      logic [2:0] partner_index;
      logic [3:0] table_count;
      logic [1:0] status;
      logic       result_last;
   } rsp_type;

endpackage

// ===== design/wtso_if.sv =====
// ----------------------------------------------------------------------------
// wtso_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface wtso_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/word_table_subword_overlap_search.sv =====
// A letter without word end is only added to the query and gives no result.
// A closing letter reads each table entry in turn (read, compare and emit states)
// and emits each result from the emit state; an error or an empty-table search
// gives a single status result instead.
// The next letter is taken only after the last result has been taken.
// Reset: synchronous, clears word count, query and output; memories are not cleared.
// ----------------------------------------------------------------------------
// word_table_subword_overlap_search
// Word table with insert/overlap, subword and superword search.
// ----------------------------------------------------------------------------
module word_table_subword_overlap_search (
   input logic clock,
   input logic reset,
   wtso_if.sink   req,
   wtso_if.source rsp
);
   import wtso_pkg::*;

   typedef enum logic [2:0] {S_IN, S_RD, S_CMP, S_EMIT, S_DONE} state_type;

   // table memories
   word_type             mem_word [TableDepth];
   logic [LenBits-1:0]   mem_len  [TableDepth];
   word_type             rd_word_ff;
   logic [LenBits-1:0]   rd_len_ff;

   state_type            state_ff;
   word_type             q_ff;
   logic [LenBits-1:0]   qlen_ff;
   logic                 ovf_ff;
   op_type               op_ff;
   logic [CntBits-1:0]   cnt_ff;
   logic [CntBits-1:0]   ent_ff;
   logic                 stop_ff;

   // per-entry match bitmap, emitted one position per cycle unless the output stalls
   logic [MaxWordLen-1:0] hits_ff;
   logic [IdxBits-1:0]    hidx_ff;
   logic [ResBits-1:0]    nres_ff;
   logic                  last_ent_ff;

   // newest result, held back until the next one or the end is known
   rsp_type               pend_ff;
   logic                  pend_ok_ff;

   rsp_type               out_ff;
   logic                  ov_ff;

   // match bitmap for the entry just read
   logic [MaxWordLen-1:0] hits;
   always_comb begin
      logic ok;
      hits = '0;
      for (int j = 0; j < MaxWordLen; j++) begin
         ok = 1'b1;
         for (int k = 0; k < MaxWordLen; k++) begin
            if (op_ff == OP_INSERT) begin
               // suffix of query from j vs prefix of entry
               if (j + k < MaxWordLen && k < int'(qlen_ff) - j
                   && rd_word_ff[k] != q_ff[j+k]) ok = 1'b0;
            end else if (op_ff == OP_SUPERS) begin
               if (k < int'(qlen_ff) && j + k < MaxWordLen
                   && q_ff[k] != rd_word_ff[j+k]) ok = 1'b0;
            end else begin
               if (k < int'(rd_len_ff) && j + k < MaxWordLen
                   && rd_word_ff[k] != q_ff[j+k]) ok = 1'b0;
            end
         end
         if (op_ff == OP_INSERT)
            hits[j] = ok && j > 0 && j < int'(qlen_ff)
                      && j + int'(rd_len_ff) > int'(qlen_ff);
         else if (op_ff == OP_SUPERS)
            hits[j] = ok && j + int'(qlen_ff) <= int'(rd_len_ff);
         else
            hits[j] = ok && j + int'(rd_len_ff) <= int'(qlen_ff);
      end
   end

   // insert reports positions descending, searches ascending
   logic [PosBits-1:0] pick;
   logic               pick_ok;
   always_comb begin
      pick = '0;
      pick_ok = 1'b0;
      for (int j = 0; j < MaxWordLen; j++) begin
         if (op_ff == OP_INSERT) begin
            if (hits_ff[j]) begin
               pick = PosBits'(j);
               pick_ok = 1'b1;
            end
         end else if (hits_ff[MaxWordLen-1-j]) begin
            pick = PosBits'(MaxWordLen-1-j);
            pick_ok = 1'b1;
         end
      end
   end

   logic out_free;
   assign out_free = !ov_ff || rsp.ready;
   assign req.ready = (state_ff == S_IN) && out_free;
   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;

   logic [IdxBits-1:0] ent_idx;
   assign ent_idx = ent_ff[IdxBits-1:0];

   logic    more;
   logic    emit_hit;
   logic    finish;
   logic    load;
   rsp_type hit_rsp;
   rsp_type load_data;
   always_comb begin
      hit_rsp = '{1'b1,
         (op_ff == OP_INSERT) ? 3'(cnt_ff - CntBits'(1)) : 3'(hidx_ff),
         3'(pick),
         (op_ff == OP_INSERT) ? 3'(hidx_ff) : 3'd0,
         4'(cnt_ff), ST_OK, 1'b0};
      more     = pick_ok && !stop_ff && int'(nres_ff) < MaxResults;
      emit_hit = (state_ff == S_EMIT) && more && (!pend_ok_ff || out_free);
      finish   = (state_ff == S_EMIT) && !more && (last_ent_ff || stop_ff) && out_free;
      load      = 1'b0;
      load_data = pend_ff;
      if (state_ff == S_IN && req.valid && req.ready && req.data.word_end) begin
         if (ovf_ff || int'(qlen_ff) >= MaxWordLen) begin
            load      = 1'b1;
            load_data = '{1'b0, 3'd0, 3'd0, 3'd0, 4'(cnt_ff), ST_LONG, 1'b1};
         end else if (req.data.op == OP_INSERT && int'(cnt_ff) >= TableDepth) begin
            load      = 1'b1;
            load_data = '{1'b0, 3'd0, 3'd0, 3'd0, 4'(cnt_ff), ST_FULL, 1'b1};
         end
      end else if (emit_hit) begin
         load = pend_ok_ff;
      end else if (finish) begin
         load = 1'b1;
         if (pend_ok_ff)
            load_data.result_last = 1'b1;
         else
            load_data = '{1'b0, 3'd0, 3'd0, 3'd0, 4'(cnt_ff), ST_OK, 1'b1};
      end
   end

   word_type wr_word;
   always_comb begin
      wr_word = q_ff;
      wr_word[qlen_ff[PosBits-1:0]] = req.data.letter[LetterBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         rd_word_ff <= mem_word[ent_idx];
         rd_len_ff  <= mem_len[ent_idx];
      end
      if (state_ff == S_IN && req.valid && req.ready && req.data.word_end
          && !ovf_ff && int'(qlen_ff) < MaxWordLen && req.data.op == OP_INSERT
          && int'(cnt_ff) < TableDepth) begin
         mem_word[cnt_ff[IdxBits-1:0]] <= wr_word;
         mem_len[cnt_ff[IdxBits-1:0]]  <= qlen_ff + LenBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff  <= 1'b0;
         out_ff <= '0;
      end else if (load) begin
         ov_ff  <= 1'b1;
         out_ff <= load_data;
      end else if (rsp.ready) begin
         ov_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
         q_ff     <= '0;
         qlen_ff  <= '0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= '0;
         op_ff    <= OP_INSERT;
         ent_ff   <= '0;
         stop_ff  <= 1'b0;
         hits_ff  <= '0;
         hidx_ff  <= '0;
         nres_ff  <= '0;
         last_ent_ff <= 1'b0;
         pend_ff  <= '0;
         pend_ok_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IN: begin
               if (req.valid && req.ready) begin
                  if (int'(qlen_ff) < MaxWordLen) begin
                     q_ff[qlen_ff[PosBits-1:0]] <= req.data.letter[LetterBits-1:0];
                     qlen_ff <= qlen_ff + LenBits'(1);
                  end
                  if (req.data.word_end) begin
                     op_ff   <= op_type'(req.data.op);
                     ent_ff  <= '0;
                     nres_ff <= '0;
                     stop_ff <= 1'b0;
                     pend_ok_ff <= 1'b0;
                     if (ovf_ff || int'(qlen_ff) >= MaxWordLen) begin
                        state_ff <= S_DONE;
                     end else if (req.data.op == OP_INSERT
                                  && int'(cnt_ff) >= TableDepth) begin
                        state_ff <= S_DONE;
                     end else begin
                        if (req.data.op == OP_INSERT) cnt_ff <= cnt_ff + CntBits'(1);
                        state_ff <= (req.data.op == OP_INSERT || cnt_ff != '0)
                                    ? S_RD : S_EMIT;
                        last_ent_ff <= 1'b1;
                        hits_ff <= '0;
                     end
                  end else if (int'(qlen_ff) >= MaxWordLen) begin
                     ovf_ff <= 1'b1;
                  end
               end
            end
            S_RD: state_ff <= S_CMP;
            S_CMP: begin
               hits_ff  <= hits;
               hidx_ff  <= ent_idx;
               last_ent_ff <= (ent_ff + CntBits'(1) >= cnt_ff);
               ent_ff   <= ent_ff + CntBits'(1);
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_hit) begin
                  hits_ff[pick] <= 1'b0;
                  pend_ff    <= hit_rsp;
                  pend_ok_ff <= 1'b1;
                  nres_ff    <= nres_ff + ResBits'(1);
                  if (op_ff == OP_FIRST) stop_ff <= 1'b1;
               end else if (!more && !last_ent_ff && !stop_ff) begin
                  state_ff <= S_RD;
               end else if (finish) begin
                  pend_ok_ff <= 1'b0;
                  state_ff   <= S_DONE;
               end
            end
            S_DONE: begin
               q_ff    <= '0;
               qlen_ff <= '0;
               ovf_ff  <= 1'b0;
               if (!ov_ff) state_ff <= S_IN;
            end
            default: state_ff <= S_IN;
         endcase
      end
   end

   // check the count bound, ready in the input state, each result held until taken, and the done exit
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= TableDepth) else $error("count overflow");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IN && !ov_ff) else $error("ready");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while waiting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && ov_ff |=> state_ff == S_DONE || !$past(ov_ff))
      else $error("done exit");

endmodule
